// ----- sv/mse_pkg.sv -----
// Shared types and sizing constants for the merge sort engine.
// No dependencies; imported by mse_ram, merge_sort_engine_top and the testbench.
package mse_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    // count width holds the value MAX_ITEMS itself
    localparam int CNT_W     = IDX_W + 1;
    // one extra bit for run-end sums before clamping to the set size
    localparam int EXT_W     = CNT_W + 1;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     final_item;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_result;
    } out_beat_t;

endpackage

// ----- sv/mse_ram.sv -----
// One bank of value storage: one write port, two registered read ports.
// Depends on mse_pkg for depth and data width.
module mse_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [mse_pkg::IDX_W-1:0]      waddr,
    input  logic signed [mse_pkg::DATA_W-1:0] wdata,
    input  logic [mse_pkg::IDX_W-1:0]      raddr_a,
    input  logic [mse_pkg::IDX_W-1:0]      raddr_b,
    output logic signed [mse_pkg::DATA_W-1:0] rdata_a,
    output logic signed [mse_pkg::DATA_W-1:0] rdata_b
);
    import mse_pkg::*;

    logic signed [DATA_W-1:0] mem [MAX_ITEMS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered reads, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- sv/merge_sort_engine_top.sv -----
// Merge sort engine top: load, bottom-up stable merge, then burst output.
// Depends on mse_pkg and mse_ram (two ping-pong banks).
//
// Values are loaded one beat per cycle into bank 0 until a beat with
// final_item set arrives or the store reaches MAX_ITEMS entries. The set of
// n values is then sorted ascending by a stable bottom-up merge: one shared
// signed comparator picks one element per cycle, reading both run heads
// from one bank and writing the other, over ceil(log2 n) passes, each
// opened by S_TURN, which primes the bank reads. Output then streams one
// beat per cycle while result_stall is low, after S_PRIME primes the read,
// final_result set on the last. sample_stall is high from the closing beat
// of a set until its last result is loaded into the output register; the
// output register lets a new set start loading while that beat waits.
module merge_sort_engine_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  mse_pkg::in_beat_t  sample_beat,
    output logic               result_valid,
    input  logic               result_stall,
    output mse_pkg::out_beat_t result_beat
);
    import mse_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_TURN,
        S_MERGE,
        S_PRIME,
        S_EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic             src_reg, src_next;
    logic             out_valid_reg, out_valid_next;
    out_beat_t        out_beat_reg, out_beat_next;

    // bank ports
    logic                     we0, we1;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] b0_a, b0_b, b1_a, b1_b;
    logic signed [DATA_W-1:0] rd_i, rd_j;

    logic                     take_i;
    logic                     load_out;
    logic [EXT_W-1:0]         w_ext;

    // clamp a run boundary to the set size
    function automatic logic [CNT_W-1:0] clamp_n(input logic [EXT_W-1:0] v,
                                                 input logic [CNT_W-1:0] n);
        logic [EXT_W-1:0] n_ext;
        n_ext = EXT_W'(n);
        clamp_n = (v > n_ext) ? n : v[CNT_W-1:0];
    endfunction

    mse_ram u_bank0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (i_next[IDX_W-1:0]),
        .raddr_b (j_next[IDX_W-1:0]),
        .rdata_a (b0_a),
        .rdata_b (b0_b)
    );

    mse_ram u_bank1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (i_next[IDX_W-1:0]),
        .raddr_b (j_next[IDX_W-1:0]),
        .rdata_a (b1_a),
        .rdata_b (b1_b)
    );

    // read data always belongs to the current source bank
    assign rd_i = src_reg ? b1_a : b0_a;
    assign rd_j = src_reg ? b1_b : b0_b;

    // shared comparator: left run wins ties
    assign take_i = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (rd_i <= rd_j));

    assign w_ext    = EXT_W'(width_reg);
    assign load_out = !out_valid_reg || !result_stall;

    assign sample_stall = (state_reg != S_LOAD);
    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        width_next     = width_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_beat_next  = out_beat_reg;
        we0            = 1'b0;
        we1            = 1'b0;
        waddr          = k_reg[IDX_W-1:0];
        wdata          = take_i ? rd_i : rd_j;

        case (state_reg)
            S_LOAD:
            begin
                if (sample_valid)
                begin
                    we0      = 1'b1;
                    waddr    = cnt_reg[IDX_W-1:0];
                    wdata    = sample_beat.sample_value;
                    cnt_next = cnt_reg + 1'b1;
                    src_next = 1'b0;
                    if (sample_beat.final_item || (cnt_next == MAX_CNT))
                    begin
                        width_next = CNT_W'(1);
                        state_next = (cnt_next == CNT_W'(1)) ? S_PRIME : S_TURN;
                    end
                end
            end

            S_TURN:
            begin
                // first run pair of a pass; width < n here
                i_next     = '0;
                k_next     = '0;
                mid_next   = width_reg;
                j_next     = width_reg;
                hi_next    = clamp_n(w_ext << 1, cnt_reg);
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                we0    = src_reg;
                we1    = !src_reg;
                i_next = i_reg + CNT_W'(take_i);
                j_next = j_reg + CNT_W'(!take_i);
                k_next = k_reg + 1'b1;
                if (k_next == hi_reg)
                begin
                    if (hi_reg == cnt_reg)
                    begin
                        // pass complete: swap banks
                        width_next = width_reg << 1;
                        src_next   = !src_reg;
                        state_next = (width_next >= cnt_reg) ? S_PRIME : S_TURN;
                    end
                    else
                    begin
                        // next run pair starts at hi
                        i_next   = hi_reg;
                        k_next   = hi_reg;
                        mid_next = clamp_n(EXT_W'(hi_reg) + w_ext, cnt_reg);
                        j_next   = mid_next;
                        hi_next  = clamp_n(EXT_W'(hi_reg) + (w_ext << 1), cnt_reg);
                    end
                end
            end

            S_PRIME:
            begin
                i_next     = '0;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next             = 1'b1;
                    out_beat_next.sorted_value = rd_i;
                    out_beat_next.final_result = (i_reg == cnt_reg - 1'b1);
                    i_next                     = i_reg + 1'b1;
                    if (i_reg == cnt_reg - 1'b1)
                    begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            width_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            width_reg     <= width_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

`ifndef ASSERT_OFF
    // merge write index stays inside the set
    a_k_in_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (k_reg < cnt_reg))
        else $error("merge write index beyond set size");

    // run heads never pass their run ends
    a_heads_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> ((i_reg <= mid_reg) && (j_reg <= hi_reg)))
        else $error("merge run head past run end");

    // a pass only starts while runs are still narrower than the set
    a_turn_width: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TURN) |-> ((width_reg < cnt_reg) && (cnt_reg > CNT_W'(1))))
        else $error("merge pass started with nothing left to merge");

    // a closing result beat sends the engine back to loading
    a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && load_out && (i_reg == cnt_reg - 1'b1))
        |=> (out_valid_reg && out_beat_reg.final_result && (state_reg == S_LOAD)))
        else $error("final result beat not followed by load state");
`endif

endmodule

// ----- test/tb_merge_sort_engine_top.sv -----
`timescale 1ns / 100ps
// Testbench for merge_sort_engine_top: directed table, then random sets under idling phases.
// Depends on mse_pkg and the engine RTL; beats checked against a built-in sorter model or pinned rows.
module tb_merge_sort_engine_top;
    import mse_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int N_PHASES        = 4;
    localparam int N_DIRECTED      = 25;
    // extra wait after the last expected result has been checked
    localparam int DRAIN_CYCLES    = 400;
    localparam int PRINT_CAP       = 40;

    localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EXTREME} value_mode_t;

    // one directed beat; pinned rows carry a hand-written expected result
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     closes;
        bit                       pinned;
        logic signed [DATA_W-1:0] pinned_value;
    } dir_row_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      sample_valid = 1'b0;
    in_beat_t  sample_beat  = '0;
    logic      result_stall = 1'b0;
    logic      sample_stall;
    logic      result_valid;
    out_beat_t result_beat;

    // sorter model state: the set being loaded, kept in sorted order
    logic signed [DATA_W-1:0] held_values [MAX_ITEMS];
    int unsigned              held_count = 0;
    out_beat_t                closing_burst [$];
    out_beat_t                sorted_due [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int mismatch_count = 0;
    int beats_sent = 0;
    int sets_closed = 0;
    int results_checked = 0;

    int idle_by_phase  [N_PHASES] = '{0, 75, 0, 30};
    int stall_by_phase [N_PHASES] = '{0, 0, 75, 30};

    dir_row_t directed_rows [N_DIRECTED];

    merge_sort_engine_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_beat  (sample_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    always #CLK_HALF clk = ~clk;

    // Sorter model: stable insertion keeps equal values in arrival order.
    // A set closes on the flagged beat or on the beat that fills the store.
    function automatic void absorb_sample(input in_beat_t beat);
        int j;
        closing_burst.delete();
        if (held_count >= MAX_ITEMS)
            held_count = 0;
        j = held_count;
        while (j > 0 && held_values[j-1] > beat.sample_value)
        begin
            held_values[j] = held_values[j-1];
            j--;
        end
        held_values[j] = beat.sample_value;
        held_count++;
        if (beat.final_item || held_count >= MAX_ITEMS)
        begin
            for (int k = 0; k < held_count; k++)
                closing_burst.push_back('{sorted_value: held_values[k],
                                          final_result: (k == held_count - 1)});
            held_count = 0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Present one beat and hold it until the engine takes it.
    task automatic send_beat(input logic signed [DATA_W-1:0] value, input logic closes);
        sample_valid <= 1'b1;
        sample_beat  <= '{sample_value: value, final_item: closes};
        do
            @(posedge clk);
        while (sample_stall);
        beats_sent++;
    endtask

    // Drop valid for a random stretch, per the current phase.
    task automatic sender_gap();
        if ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid <= 1'b0;
            sample_beat  <= '{sample_value: $urandom, final_item: 1'($urandom_range(1))};
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input value_mode_t mode);
        logic signed [DATA_W-1:0] v;
        case (mode)
            VAL_WIDE:   v = $urandom;
            VAL_NARROW: v = DATA_W'($urandom_range(6)) - DATA_W'(3);
            default:
            begin
                case ($urandom_range(5))
                    0:       v = MOST_NEG;
                    1:       v = MOST_POS;
                    2:       v = '0;
                    3:       v = '1;
                    4:       v = MOST_NEG + 1;
                    default: v = MOST_POS - 1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Result side: check each accepted beat, then pick next cycle's stall.
    always @(posedge clk)
    begin
        out_beat_t due;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (sorted_due.size() == 0)
                report_mismatch($sformatf("unexpected result value %0d last %0b",
                                          result_beat.sorted_value, result_beat.final_result));
            else
            begin
                due = sorted_due.pop_front();
                if (result_beat.sorted_value !== due.sorted_value)
                    report_mismatch($sformatf("sorted_value got %0d want %0d",
                                              result_beat.sorted_value, due.sorted_value));
                if (result_beat.final_result !== due.final_result)
                    report_mismatch($sformatf("final_result got %0b want %0b on value %0d",
                                              result_beat.final_result, due.final_result,
                                              due.sorted_value));
            end
        end
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Run limit, well above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", sorted_due.size());
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        int size;
        int phase_items;
        logic closes;
        value_mode_t mode;

        // single-value sets at the extremes: result is the value itself
        directed_rows[0] = '{MOST_NEG, 1'b1, 1'b1, MOST_NEG};
        directed_rows[1] = '{MOST_POS, 1'b1, 1'b1, MOST_POS};
        directed_rows[2] = '{32'sd0,   1'b1, 1'b1, 32'sd0};
        directed_rows[3] = '{-32'sd1,  1'b1, 1'b1, -32'sd1};
        // two values out of order
        directed_rows[4] = '{MOST_POS, 1'b0, 1'b0, '0};
        directed_rows[5] = '{MOST_NEG, 1'b1, 1'b0, '0};
        // equal values
        directed_rows[6] = '{32'sd5, 1'b0, 1'b0, '0};
        directed_rows[7] = '{32'sd5, 1'b0, 1'b0, '0};
        directed_rows[8] = '{32'sd5, 1'b1, 1'b0, '0};
        // full store closes the set without a flag
        directed_rows[9]  = '{MOST_POS,        1'b0, 1'b0, '0};
        directed_rows[10] = '{MOST_NEG,        1'b0, 1'b0, '0};
        directed_rows[11] = '{32'sd3,          1'b0, 1'b0, '0};
        directed_rows[12] = '{-32'sd3,         1'b0, 1'b0, '0};
        directed_rows[13] = '{32'sd0,          1'b0, 1'b0, '0};
        directed_rows[14] = '{-32'sd1,         1'b0, 1'b0, '0};
        directed_rows[15] = '{32'sd1,          1'b0, 1'b0, '0};
        directed_rows[16] = '{32'sh5555_5555,  1'b0, 1'b0, '0};
        directed_rows[17] = '{32'shAAAA_AAAA,  1'b0, 1'b0, '0};
        directed_rows[18] = '{MOST_POS - 1,    1'b0, 1'b0, '0};
        directed_rows[19] = '{MOST_NEG + 1,    1'b0, 1'b0, '0};
        directed_rows[20] = '{32'sd3,          1'b0, 1'b0, '0};
        directed_rows[21] = '{-32'sd3,         1'b0, 1'b0, '0};
        directed_rows[22] = '{32'sd42,         1'b0, 1'b0, '0};
        directed_rows[23] = '{32'sd0,          1'b0, 1'b0, '0};
        directed_rows[24] = '{-32'sd42,        1'b0, 1'b0, '0};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, no idling
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_beat(directed_rows[r].value, directed_rows[r].closes);
            absorb_sample('{sample_value: directed_rows[r].value,
                            final_item: directed_rows[r].closes});
            if (closing_burst.size() != 0)
                sets_closed++;
            if (directed_rows[r].pinned)
                sorted_due.push_back('{sorted_value: directed_rows[r].pinned_value,
                                       final_result: 1'b1});
            else
                foreach (closing_burst[k])
                    sorted_due.push_back(closing_burst[k]);
        end

        // random sets, one idling phase at a time
        for (int p = 0; p < N_PHASES; p++)
        begin
            sender_idle_pct    = idle_by_phase[p];
            receiver_stall_pct = stall_by_phase[p];
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(99)) inside
                    [0:69]:  size = $urandom_range(1, 5);
                    [70:84]: size = $urandom_range(6, MAX_ITEMS - 1);
                    default: size = MAX_ITEMS;
                endcase
                mode = value_mode_t'($urandom_range(2));
                for (int i = 0; i < size; i++)
                begin
                    // a full set may or may not flag its last beat
                    if (i == size - 1)
                        closes = (size == MAX_ITEMS) ? 1'($urandom_range(1)) : 1'b1;
                    else
                        closes = 1'b0;
                    sender_gap();
                    send_beat(pick_value(mode), closes);
                    absorb_sample(sample_beat);
                    foreach (closing_burst[k])
                        sorted_due.push_back(closing_burst[k]);
                    phase_items++;
                end
                sets_closed++;
            end
        end

        sample_valid <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats in %0d sets over %0d idling phases; %0d results checked",
                 beats_sent, sets_closed, N_PHASES, results_checked);
        if (mismatch_count == 0 && sorted_due.size() == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
